### hdl/rhmf_pkg.sv
// shared constants, codes and controller/datapath interface types
package rhmf_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MAX_RADIUS = 7;
  localparam int LEVELS     = 256;
  localparam int STORE_ROWS = 2 * MAX_RADIUS + 2;
  localparam int MAX_WIN    = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);

  localparam int CH_W      = 8;
  localparam int PIX_W     = 3 * CH_W;
  localparam int RAD_W     = 3;
  localparam int DIM_W     = 11;
  localparam int POS_W     = $clog2(MAX_WIDTH);
  localparam int ROW_SEL_W = $clog2(STORE_ROWS);
  localparam int LS_DEPTH  = STORE_ROWS * MAX_WIDTH;
  localparam int LS_AW     = $clog2(LS_DEPTH);
  localparam int Q_W       = 21;
  localparam int LAG_W     = 13;
  localparam int DIV_CNT_W = $clog2(Q_W);
  localparam int CNT_W     = $clog2(MAX_WIN + 1);
  localparam int K_W       = $clog2(LEVELS) + 1;
  localparam int HADDR_W   = $clog2(LEVELS);
  localparam int OUT_W     = 48;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;

  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef struct packed {
    logic accept;
    logic div_start;
    logic lat_in;
    logic wr_line;
    logic lat_out;
    logic win_init;
    logic win_hr;
    logic win_hw;
    logic scan;
    logic clr;
    logic load;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic no_out;
    logic win_last;
    logic scan_done;
    logic clr_done;
    logic out_free;
  } dp_sts_t;

endpackage

### hdl/rhmf_ram.sv
// generic simple dual-port ram with registered read
module rhmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hdl/rhmf_div.sv
// restoring divider, one quotient bit per cycle
module rhmf_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [rhmf_pkg::Q_W-1:0]   dividend,
  input  logic [rhmf_pkg::DIM_W-1:0] divisor,
  output logic                      done,
  output logic [rhmf_pkg::Q_W-1:0]   quo,
  output logic [rhmf_pkg::DIM_W-1:0] rem
);
  import rhmf_pkg::*;

  logic                 run_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [Q_W-1:0]       quo_r;
  logic [DIM_W-1:0]     rem_r;
  logic [DIM_W-1:0]     dvs_r;
  logic [DIM_W:0]       trial;
  logic                 ge;

  assign trial = {rem_r, quo_r[Q_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(Q_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (run_r) begin
      quo_r <= {quo_r[Q_W-2:0], ge};
      rem_r <= ge ? DIM_W'(trial - {1'b0, dvs_r}) : trial[DIM_W-1:0];
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

### hdl/rhmf_ctrl.sv
// sequencer: histogram clear after reset, per item division and write, window histogram build, rank scan, result load
module rhmf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  rhmf_pkg::dp_sts_t sts,
  output rhmf_pkg::dp_cmd_t cmd
);
  import rhmf_pkg::*;

  typedef enum logic [10:0] {
    S_CLR  = 11'b000_0000_0001,
    S_IDLE = 11'b000_0000_0010,
    S_DIVQ = 11'b000_0000_0100,
    S_WR   = 11'b000_0000_1000,
    S_DIVO = 11'b000_0001_0000,
    S_WSET = 11'b000_0010_0000,
    S_WRD  = 11'b000_0100_0000,
    S_WHR  = 11'b000_1000_0000,
    S_WHW  = 11'b001_0000_0000,
    S_SCAN = 11'b010_0000_0000,
    S_FIN  = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLR: begin
        cmd.clr = 1'b1;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept    = 1'b1;
          cmd.div_start = 1'b1;
          state_nxt     = S_DIVQ;
        end
      end
      S_DIVQ: begin
        if (sts.div_done) begin
          cmd.lat_in = 1'b1;
          state_nxt  = S_WR;
        end
      end
      S_WR: begin
        cmd.wr_line = 1'b1;
        if (sts.no_out) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIVO;
        end
      end
      S_DIVO: begin
        if (sts.div_done) begin
          cmd.lat_out = 1'b1;
          state_nxt   = S_WSET;
        end
      end
      S_WSET: begin
        cmd.win_init = 1'b1;
        state_nxt    = S_WRD;
      end
      S_WRD: begin
        state_nxt = S_WHR;
      end
      S_WHR: begin
        cmd.win_hr = 1'b1;
        state_nxt  = S_WHW;
      end
      S_WHW: begin
        cmd.win_hw = 1'b1;
        state_nxt  = sts.win_last ? S_SCAN : S_WRD;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLR;
    endcase
  end

endmodule

### hdl/rhmf_dp.sv
// datapath: positions, line store, per-channel histograms, rank search, output register
module rhmf_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [rhmf_pkg::RAD_W-1:0]   radius,
  input  logic [rhmf_pkg::DIM_W-1:0]   image_width,
  input  logic [rhmf_pkg::DIM_W-1:0]   image_height,
  input  logic                         in_tuser,
  input  logic [rhmf_pkg::PIX_W-1:0]   in_tdata,
  input  rhmf_pkg::dp_cmd_t            cmd,
  output rhmf_pkg::dp_sts_t            sts,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [rhmf_pkg::OUT_W-1:0]   out_tdata,
  output logic                         out_tlast
);
  import rhmf_pkg::*;

  // clamped geometry
  logic [DIM_W-1:0] w_r, h_r;
  logic [RAD_W-1:0] r_r;
  logic [Q_W-1:0]   frame_r, end_r;
  logic [LAG_W-1:0] lag_r;

  logic             op_r;
  logic [PIX_W-1:0] pix_r;
  logic [Q_W-1:0]   q_r, o_r, q_eff;
  logic [ROW_SEL_W-1:0] in_sel_r;
  logic [POS_W-1:0] in_col_r;
  logic [POS_W-1:0] orow_r, ocol_r;
  logic [POS_W-1:0] i_r, j_r, r1_r, c0_r, c1_r;
  logic [CNT_W-1:0] n_r;
  logic [PIX_W-1:0] px_r;
  logic [K_W-1:0]   k_r;
  logic [K_W-1:0]   k_dec;

  logic [CH_W-1:0]  acc_r [3];
  logic [CH_W-1:0]  med_r [3];
  logic [2:0]       found_r;

  logic             out_valid_r;
  logic [OUT_W-1:0] out_data_r;
  logic             out_last_r;

  logic             div_start, div_done;
  logic [Q_W-1:0]   div_dividend, div_quo;
  logic [DIM_W-1:0] div_rem;

  logic [PIX_W-1:0] ls_rdata, ls_wdata;
  logic             ls_we;
  logic [CH_W-1:0]  hrd [3];

  logic [POS_W-1:0] rr, r0, r1, c0, c1;
  logic [DIM_W-1:0] rsum, csum;
  logic             last_out;

  always_ff @(posedge clk) begin
    w_r <= (image_width == '0) ? DIM_W'(1) :
           (image_width > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : image_width;
    h_r <= (image_height == '0) ? DIM_W'(1) :
           (image_height > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : image_height;
    r_r     <= radius;
    frame_r <= Q_W'(w_r) * Q_W'(h_r);
    lag_r   <= LAG_W'(r_r) * LAG_W'(w_r) + LAG_W'(r_r);
    end_r   <= frame_r + Q_W'(lag_r);
  end

  // a count that has reached the end of the frame and its drain beats starts a new one
  assign q_eff = (q_r >= end_r) ? '0 : q_r;

  assign div_start    = cmd.div_start;
  assign div_dividend = cmd.accept ? q_eff : (q_r - Q_W'(lag_r));

  rhmf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (w_r),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  assign last_out = (o_r == frame_r - 1'b1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else if (cmd.accept) begin
      q_r <= q_eff;
    end else if (cmd.wr_line) begin
      q_r <= q_r + 1'b1;
    end else if (cmd.load && last_out) begin
      q_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r  <= in_tuser;
      pix_r <= in_tdata;
    end
    if (cmd.lat_in) begin
      in_sel_r <= div_quo[ROW_SEL_W-1:0];
      in_col_r <= div_rem[POS_W-1:0];
    end
    if (cmd.wr_line) begin
      o_r <= q_r - Q_W'(lag_r);
    end
    if (cmd.lat_out) begin
      orow_r <= div_quo[POS_W-1:0];
      ocol_r <= div_rem[POS_W-1:0];
    end
  end

  // clipped window bounds
  assign rr   = POS_W'(r_r);
  assign rsum = {1'b0, orow_r} + DIM_W'(r_r);
  assign csum = {1'b0, ocol_r} + DIM_W'(r_r);
  assign r0   = (orow_r > rr) ? orow_r - rr : '0;
  assign c0   = (ocol_r > rr) ? ocol_r - rr : '0;
  assign r1   = (rsum < h_r) ? rsum[POS_W-1:0] : POS_W'(h_r - 1'b1);
  assign c1   = (csum < w_r) ? csum[POS_W-1:0] : POS_W'(w_r - 1'b1);

  always_ff @(posedge clk) begin
    if (cmd.win_init) begin
      i_r  <= r0;
      j_r  <= c0;
      r1_r <= r1;
      c0_r <= c0;
      c1_r <= c1;
      n_r  <= '0;
    end else if (cmd.win_hw) begin
      n_r <= n_r + 1'b1;
      if (j_r == c1_r) begin
        j_r <= c0_r;
        i_r <= i_r + 1'b1;
      end else begin
        j_r <= j_r + 1'b1;
      end
    end
    if (cmd.win_hr) begin
      px_r <= ls_rdata;
    end
  end

  // line store: row modulo store depth, column
  assign ls_we    = cmd.wr_line && (q_r < frame_r);
  assign ls_wdata = (op_r == OP_DRAIN) ? '0 : pix_r;

  rhmf_ram #(.WIDTH(PIX_W), .DEPTH(LS_DEPTH)) u_line_store (
    .clk   (clk),
    .we    (ls_we),
    .waddr ({in_sel_r, in_col_r}),
    .wdata (ls_wdata),
    .raddr ({i_r[ROW_SEL_W-1:0], j_r}),
    .rdata (ls_rdata)
  );

  // scan and clearing counter
  assign k_dec = k_r - 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= '0;
    end else if (cmd.clr) begin
      k_r <= sts.clr_done ? '0 : k_r + 1'b1;
    end else if (cmd.scan) begin
      k_r <= sts.scan_done ? '0 : k_r + 1'b1;
    end
  end

  // per-channel histograms; channel 0 is red, in the low byte of a pixel word
  for (genvar c = 0; c < 3; c++) begin : g_ch
    logic [CH_W-1:0]    sel_byte, px_byte, acc_nxt;
    logic [HADDR_W-1:0] h_raddr, h_waddr;
    logic               h_we;
    logic [CH_W-1:0]    h_wdata;

    assign sel_byte = ls_rdata[CH_W*c +: CH_W];
    assign px_byte  = px_r[CH_W*c +: CH_W];
    assign h_raddr  = cmd.scan ? k_r[HADDR_W-1:0] : sel_byte;
    assign h_we     = cmd.win_hw || (cmd.scan && (k_r != '0)) || cmd.clr;
    assign h_waddr  = cmd.win_hw ? px_byte :
                      cmd.scan   ? k_dec[HADDR_W-1:0] : k_r[HADDR_W-1:0];
    assign h_wdata  = cmd.win_hw ? hrd[c] + 1'b1 : '0;
    assign acc_nxt  = acc_r[c] + hrd[c];

    rhmf_ram #(.WIDTH(CH_W), .DEPTH(LEVELS)) u_hist (
      .clk   (clk),
      .we    (h_we),
      .waddr (h_waddr),
      .wdata (h_wdata),
      .raddr (h_raddr),
      .rdata (hrd[c])
    );

    // first bin whose running sum passes half the window count
    always_ff @(posedge clk) begin
      if (cmd.win_init) begin
        acc_r[c]   <= '0;
        med_r[c]   <= CH_W'(LEVELS - 1);
        found_r[c] <= 1'b0;
      end else if (cmd.scan && (k_r != '0)) begin
        acc_r[c] <= acc_nxt;
        if (!found_r[c] && (acc_nxt > (n_r >> 1))) begin
          found_r[c] <= 1'b1;
          med_r[c]   <= k_dec[CH_W-1:0];
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_data_r <= {(OUT_W - 2 * POS_W - PIX_W)'(0), ocol_r, orow_r,
                     med_r[2], med_r[1], med_r[0]};
      out_last_r <= last_out;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  assign sts.div_done  = div_done;
  assign sts.no_out    = q_r < Q_W'(lag_r);
  assign sts.win_last  = (i_r == r1_r) && (j_r == c1_r);
  assign sts.scan_done = (k_r == K_W'(LEVELS));
  assign sts.clr_done  = (k_r == K_W'(LEVELS - 1));
  assign sts.out_free  = !out_valid_r || out_tready;

`ifndef NO_ASSERTIONS
  a_win_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.win_hw |-> n_r < CNT_W'(MAX_WIN))
    else $error("window pixel count beyond the largest window");

  a_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan |-> (acc_r[0] <= n_r) && (acc_r[1] <= n_r) && (acc_r[2] <= n_r))
    else $error("histogram sum exceeds window count");

  a_med_found: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (found_r == 3'b111))
    else $error("median not found in histogram scan");

  a_load_shown: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> out_tvalid)
    else $error("loaded result not presented");
`endif

endmodule

### hdl/rgb_histogram_median_filter.sv
// top level: configuration registers, controller and datapath
//
// Median filter for RGB pixels in raster order, each channel separately over the
// same clipped (2R+1) x (2R+1) window. Pixels enter on the in_ stream (tuser 0 =
// pixel, 1 = drain beat); results leave on the out_ stream with their row and
// column, tlast marking the final pixel of the frame. The result of beat q is
// output pixel q - (R*W + R); after the last pixel of a frame, R*W + R drain
// beats flush the rest. Radius, width and height are set over the cfg_ port
// (byte addresses 0, 4, 8); the user must write them only while the block is
// idle, as the block itself does not enforce it. A beat without a result waits
// on the serial divider that turns the item count into row and column. A beat
// with a result adds a second division, window setup, a histogram scan over all
// bins and the result load, plus a line store read, a histogram read and a
// histogram write for each window pixel. The result then waits in an output
// register; the next beat is taken while it is held, and a finished result
// stalls only if the previous one has still not been taken.
// After reset a pass clears the histograms with in_tready low.
module rgb_histogram_median_filter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [rhmf_pkg::PIX_W-1:0]    in_tdata,   // red, green, blue
  input  logic                          in_tuser,   // opcode
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [rhmf_pkg::OUT_W-1:0]    out_tdata,  // out_red, out_green, out_blue, out_row, out_col
  output logic                          out_tlast,  // frame_last
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [rhmf_pkg::ADDR_W-1:0]   cfg_paddr,
  input  logic [rhmf_pkg::DATA_W-1:0]   cfg_pwdata,
  output logic [rhmf_pkg::DATA_W-1:0]   cfg_prdata,
  output logic                          cfg_pready
);
  import rhmf_pkg::*;

  logic [RAD_W-1:0] radius_r;
  logic [DIM_W-1:0] width_r, height_r;
  logic             cfg_wr;
  dp_cmd_t          cmd;
  dp_sts_t          sts;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RAD_W'(1);
      width_r  <= DIM_W'(MAX_WIDTH);
      height_r <= DIM_W'(MAX_HEIGHT);
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_RADIUS: radius_r <= cfg_pwdata[RAD_W-1:0];
        REG_WIDTH:  width_r  <= cfg_pwdata[DIM_W-1:0];
        REG_HEIGHT: height_r <= cfg_pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_RADIUS: cfg_prdata = DATA_W'(radius_r);
      REG_WIDTH:  cfg_prdata = DATA_W'(width_r);
      REG_HEIGHT: cfg_prdata = DATA_W'(height_r);
      default:    cfg_prdata = '0;
    endcase
  end

  rhmf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rhmf_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .radius       (radius_r),
    .image_width  (width_r),
    .image_height (height_r),
    .in_tuser     (in_tuser),
    .in_tdata     (in_tdata),
    .cmd          (cmd),
    .sts          (sts),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast)
  );

endmodule
